>>> sv/polyline_point_hit_test_defines.svh
// Assertion macros shared by the polyline hit test RTL.
// No dependencies; included by the controller and datapath files.
`ifndef POLYLINE_POINT_HIT_TEST_DEFINES_SVH
`define POLYLINE_POINT_HIT_TEST_DEFINES_SVH

`ifndef ASSERT_OFF

// Clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/plhit_pkg.sv
// Types, constants and codes for the polyline hit test block.
// No dependencies; imported by the top level, controller and datapath.
package plhit_pkg;

    // Store and coordinate sizes
    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 32;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int VTX_W        = 2 * COORD_BITS;

    // Arithmetic widths
    localparam int TOL_W  = 31;
    localparam int TOL2_W = 2 * TOL_W;
    localparam int DIFF_W = COORD_BITS + 1;  // difference of two coordinates
    localparam int MAG_W  = COORD_BITS;      // its magnitude
    localparam int MUL_W  = 33;              // shared multiplier operand
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 2 * PROD_W;

    // Partial product alignment
    localparam int SH_HALF  = MUL_W;
    localparam int SH_CROSS = MUL_W + 1;     // cross term of a square, doubled
    localparam int SH_FULL  = 2 * MUL_W;

    // Segment sequencer
    localparam int STEP_W = 4;

    // Request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
    } t_req;

    typedef struct packed {
        logic             hit_found;
        logic [CNT_W-1:0] vertex_count;
        logic             store_full;
    } t_result;

    // Multiplier operand pairs
    typedef enum logic [3:0] {
        MOP_TOL_TOL,
        MOP_EY_DX,
        MOP_EX_DY,
        MOP_DX_DX,
        MOP_DY_DY,
        MOP_ALO_ALO,
        MOP_ALO_AHI,
        MOP_AHI_AHI,
        MOP_T2LO_LLO,
        MOP_T2LO_LHI,
        MOP_T2HI_LLO,
        MOP_T2HI_LHI,
        MOP_EX_EX,
        MOP_EY_EY
    } t_mop;

    // Where a product lands in the cycle after it is registered
    typedef enum logic [3:0] {
        DST_NONE,
        DST_TOL2,
        DST_P1,
        DST_P2,
        DST_LEN_SET,
        DST_LEN_ADD,
        DST_LHS_SET,
        DST_LHS_ADD,
        DST_LHS_ADD_X2,
        DST_LHS_ADD_HI,
        DST_RHS_SET,
        DST_RHS_ADD_MID,
        DST_RHS_ADD_HI
    } t_dst;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TOL,
        S_RD,
        S_LD,
        S_VTX,
        S_SEG,
        S_ZSEG,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr_cnt;
        logic append;
        logic q_load;
        logic ld;
        logic vtx_chk;
        logic a_calc;
        logic cmp;
        logic cmp_zero;
        logic res_load;
        logic res_full;
        logic res_hit;
        t_mop mop;
        t_dst dst;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_lt2;
        logic full;
        logic first;
        logic last;
        logic vtx_hit;
        logic in_box;
        logic zero_len;
        logic hit_zero;
        logic hit_seg;
    } t_sts;

endpackage

>>> sv/polyline_point_hit_test.sv
// Top level of the polyline hit test: controller, datapath and vertex store.
// Depends on plhit_pkg, plhit_ram, plhit_ctrl and plhit_dp.
//
//   channel   | ports                        | handshake
//   ----------+------------------------------+-------------------------------
//   request   | i_req (t_req)                | start high while busy is low
//   result    | o_result (t_result)          | o_valid high for one cycle
//   config    | i_cfg_wdata (hit_tolerance)  | i_cfg_we high, no wait
//
// Clear, append and unused codes are answered from idle; busy stays low and
// the result strobes in the next cycle. A query with N >= 2 vertices reads
// each vertex through S_RD, S_LD and S_VTX and runs the segment test steps on
// every segment whose bounding box holds the point (the zero-length steps for
// a zero-length one). The single shared 33x33 multiplier sets the segment
// cost. It stops early on the first hit. Reset is synchronous, active low;
// it empties the line and clears the tolerance. Results are never held off.
module polyline_point_hit_test
    import plhit_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output t_result          o_result
);

    t_cmd              cmd;
    t_sts              sts;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VTX_W-1:0]  ram_wdata, ram_rdata;

    plhit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    plhit_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Vertex store: x in the upper half, y in the lower half
    plhit_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

>>> sv/plhit_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module plhit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/plhit_ctrl.sv
// Controller for the polyline hit test: request decode, vertex scan and
// segment test sequencing. Depends on plhit_pkg and the assertion macros.
`include "polyline_point_hit_test_defines.svh"

module plhit_ctrl
    import plhit_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_req_type,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    // Segment test steps
    localparam logic [STEP_W-1:0] ST_P1     = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_P2     = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_DX2    = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_DY2    = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_ALO2   = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_ACROSS = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_AHI2   = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_R0     = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_R1     = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_R2     = STEP_W'(9);
    localparam logic [STEP_W-1:0] ST_R3     = STEP_W'(10);
    localparam logic [STEP_W-1:0] ST_WAIT   = STEP_W'(11);
    localparam logic [STEP_W-1:0] ST_CMP    = STEP_W'(12);

    // Zero-length segment steps
    localparam logic [STEP_W-1:0] ZT_EX2  = STEP_W'(0);
    localparam logic [STEP_W-1:0] ZT_EY2  = STEP_W'(1);
    localparam logic [STEP_W-1:0] ZT_WAIT = STEP_W'(2);
    localparam logic [STEP_W-1:0] ZT_CMP  = STEP_W'(3);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_valid;
    t_cmd                cmd;

    // State, step and strobe registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_valid <= cmd.res_load;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        cmd.mop = MOP_TOL_TOL;
        cmd.dst = DST_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_req_type)
                        REQ_CLEAR: begin
                            cmd.clr_cnt  = 1'b1;
                            cmd.res_load = 1'b1;
                        end
                        REQ_APPEND: begin
                            if (i_sts.full) begin
                                cmd.res_full = 1'b1;
                            end else begin
                                cmd.append = 1'b1;
                            end
                            cmd.res_load = 1'b1;
                        end
                        REQ_QUERY: begin
                            cmd.q_load = 1'b1;
                            if (i_sts.cnt_lt2) begin
                                cmd.res_load = 1'b1;
                            end else begin
                                n_state = S_TOL;
                            end
                        end
                        default: begin
                            cmd.res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_TOL: begin
                cmd.mop = MOP_TOL_TOL;
                cmd.dst = DST_TOL2;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                cmd.ld  = 1'b1;
                n_state = S_VTX;
            end
            S_VTX: begin
                cmd.vtx_chk = 1'b1;
                n_step      = '0;
                if (i_sts.vtx_hit) begin
                    n_state = S_DONE;
                end else if (!i_sts.first && i_sts.in_box) begin
                    n_state = i_sts.zero_len ? S_ZSEG : S_SEG;
                end else if (i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SEG: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    ST_P1: begin
                        cmd.mop = MOP_EY_DX;
                        cmd.dst = DST_P1;
                    end
                    ST_P2: begin
                        cmd.mop = MOP_EX_DY;
                        cmd.dst = DST_P2;
                    end
                    ST_DX2: begin
                        cmd.mop = MOP_DX_DX;
                        cmd.dst = DST_LEN_SET;
                    end
                    ST_DY2: begin
                        cmd.mop    = MOP_DY_DY;
                        cmd.dst    = DST_LEN_ADD;
                        cmd.a_calc = 1'b1;
                    end
                    ST_ALO2: begin
                        cmd.mop = MOP_ALO_ALO;
                        cmd.dst = DST_LHS_SET;
                    end
                    ST_ACROSS: begin
                        cmd.mop = MOP_ALO_AHI;
                        cmd.dst = DST_LHS_ADD_X2;
                    end
                    ST_AHI2: begin
                        cmd.mop = MOP_AHI_AHI;
                        cmd.dst = DST_LHS_ADD_HI;
                    end
                    ST_R0: begin
                        cmd.mop = MOP_T2LO_LLO;
                        cmd.dst = DST_RHS_SET;
                    end
                    ST_R1: begin
                        cmd.mop = MOP_T2LO_LHI;
                        cmd.dst = DST_RHS_ADD_MID;
                    end
                    ST_R2: begin
                        cmd.mop = MOP_T2HI_LLO;
                        cmd.dst = DST_RHS_ADD_MID;
                    end
                    ST_R3: begin
                        cmd.mop = MOP_T2HI_LHI;
                        cmd.dst = DST_RHS_ADD_HI;
                    end
                    ST_WAIT: begin
                    end
                    ST_CMP: begin
                        cmd.cmp = 1'b1;
                        n_state = (i_sts.hit_seg || i_sts.last) ? S_DONE : S_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ZSEG: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    ZT_EX2: begin
                        cmd.mop = MOP_EX_EX;
                        cmd.dst = DST_LHS_SET;
                    end
                    ZT_EY2: begin
                        cmd.mop = MOP_EY_EY;
                        cmd.dst = DST_LHS_ADD;
                    end
                    ZT_WAIT: begin
                    end
                    ZT_CMP: begin
                        cmd.cmp      = 1'b1;
                        cmd.cmp_zero = 1'b1;
                        n_state = (i_sts.hit_zero || i_sts.last) ? S_DONE : S_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                cmd.res_load = 1'b1;
                cmd.res_hit  = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // A result strobe follows either a request answered from idle or the end of a scan
    `ASSERT_IMPL(a_valid_source, i_clk, i_rst_n, r_valid,
        ($past(r_state) == S_DONE) || $past(i_start && (r_state == S_IDLE)),
        "result strobe without a finished request")

    `ASSERT_IMPL(a_seg_step_range, i_clk, i_rst_n, r_state == S_SEG, r_step <= ST_CMP,
        "segment step out of range")

    `ASSERT_CLK(a_query_goes_busy, i_clk, i_rst_n,
        (i_start && !o_busy && (i_req_type == REQ_QUERY) && !i_sts.cnt_lt2) |=> o_busy,
        "scan did not start on a query")

endmodule

>>> sv/plhit_dp.sv
// Datapath for the polyline hit test: vertex count, scan registers, shared
// multiplier with accumulators, and the result register. Depends on plhit_pkg.
`include "polyline_point_hit_test_defines.svh"

module plhit_dp
    import plhit_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [TOL_W-1:0]  i_cfg_wdata,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output t_result           o_result,
    output logic              o_ram_we,
    output logic [ADDR_W-1:0] o_ram_waddr,
    output logic [VTX_W-1:0]  o_ram_wdata,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [VTX_W-1:0]  i_ram_rdata
);

    function automatic logic signed [DIFF_W-1:0] f_sub(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    function automatic logic [MAG_W-1:0] f_mag(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] t;
        t = d[DIFF_W-1] ? (~d + 1'b1) : d;
        return t[MAG_W-1:0];
    endfunction

    // Inclusive span; a flat axis puts no limit on the point
    function automatic logic f_span(
        input logic signed [COORD_BITS-1:0] p,
        input logic signed [COORD_BITS-1:0] e0,
        input logic signed [COORD_BITS-1:0] e1
    );
        logic ok;
        if (e0 < e1) begin
            ok = (p >= e0) && (p <= e1);
        end else if (e0 > e1) begin
            ok = (p <= e0) && (p >= e1);
        end else begin
            ok = 1'b1;
        end
        return ok;
    endfunction

    logic [TOL_W-1:0]              r_tol;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_idx;
    logic                          r_hit;
    t_dst                          r_dst;
    logic signed [COORD_BITS-1:0]  r_qx, r_qy, r_px, r_py, r_cx, r_cy;
    logic [MAG_W-1:0]              r_mdx, r_mdy, r_mex, r_mey;
    logic [PROD_W-1:0]             r_prod, r_p1, r_p2, r_a, r_len;
    logic [TOL2_W-1:0]             r_tol2;
    logic [ACC_W-1:0]              r_lhs, r_rhs;
    t_result                       r_res;

    logic signed [DIFF_W-1:0]      dx, dy, ex, ey, vdx, vdy;
    logic                          vtx_hit, in_box, zero_len, sgn_mix;
    logic                          hit_zero, hit_seg;
    logic [PROD_W-1:0]             a_val;
    logic [MUL_W-1:0]              op_a, op_b;
    logic [ACC_W-1:0]              prod_ext;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Vertex count
    always_comb begin
        n_count = r_count;
        if (i_cmd.clr_cnt) begin
            n_count = '0;
        end else if (i_cmd.append) begin
            n_count = r_count + 1'b1;
        end
    end

    // Control registers: count, scan index, hit flag, product destination
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_dst   <= DST_NONE;
        end else begin
            r_count <= n_count;
            r_dst   <= i_cmd.dst;
            if (i_cmd.q_load) begin
                r_idx <= '0;
            end else if (i_cmd.ld) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.q_load) begin
                r_hit <= 1'b0;
            end else if (i_cmd.vtx_chk && vtx_hit) begin
                r_hit <= 1'b1;
            end else if (i_cmd.cmp && (i_cmd.cmp_zero ? hit_zero : hit_seg)) begin
                r_hit <= 1'b1;
            end
        end
    end

    // Vertex store ports
    assign o_ram_we    = i_cmd.append;
    assign o_ram_waddr = r_count[ADDR_W-1:0];
    assign o_ram_wdata = {i_req.coord_x, i_req.coord_y};
    assign o_ram_raddr = r_idx[ADDR_W-1:0];

    // Query point and the current segment's end points
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_load) begin
            r_qx <= i_req.coord_x;
            r_qy <= i_req.coord_y;
        end
        if (i_cmd.ld) begin
            r_px <= r_cx;
            r_py <= r_cy;
            r_cx <= $signed(i_ram_rdata[VTX_W-1:COORD_BITS]);
            r_cy <= $signed(i_ram_rdata[COORD_BITS-1:0]);
        end
    end

    // Differences and geometric tests
    assign dx  = f_sub(r_cx, r_px);
    assign dy  = f_sub(r_cy, r_py);
    assign ex  = f_sub(r_qx, r_px);
    assign ey  = f_sub(r_qy, r_py);
    assign vdx = f_sub(r_cx, r_qx);
    assign vdy = f_sub(r_cy, r_qy);

    assign vtx_hit  = (f_mag(vdx) < MAG_W'(r_tol)) && (f_mag(vdy) < MAG_W'(r_tol));
    assign in_box   = f_span(r_qx, r_px, r_cx) && f_span(r_qy, r_py, r_cy);
    assign zero_len = (dx == '0) && (dy == '0);

    // Magnitudes, registered ahead of the multiplier
    always_ff @(posedge i_clk) begin
        r_mdx <= f_mag(dx);
        r_mdy <= f_mag(dy);
        r_mex <= f_mag(ex);
        r_mey <= f_mag(ey);
    end

    // |a2| from the two cross products and their signs
    assign sgn_mix = (ey[DIFF_W-1] ^ dx[DIFF_W-1]) ^ (ex[DIFF_W-1] ^ dy[DIFF_W-1]);
    always_comb begin
        if (sgn_mix) begin
            a_val = r_p1 + r_p2;
        end else if (r_p1 >= r_p2) begin
            a_val = r_p1 - r_p2;
        end else begin
            a_val = r_p2 - r_p1;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_cmd.mop)
            MOP_TOL_TOL: begin
                op_a = MUL_W'(r_tol);
                op_b = MUL_W'(r_tol);
            end
            MOP_EY_DX: begin
                op_a = MUL_W'(r_mey);
                op_b = MUL_W'(r_mdx);
            end
            MOP_EX_DY: begin
                op_a = MUL_W'(r_mex);
                op_b = MUL_W'(r_mdy);
            end
            MOP_DX_DX: begin
                op_a = MUL_W'(r_mdx);
                op_b = MUL_W'(r_mdx);
            end
            MOP_DY_DY: begin
                op_a = MUL_W'(r_mdy);
                op_b = MUL_W'(r_mdy);
            end
            MOP_ALO_ALO: begin
                op_a = r_a[MUL_W-1:0];
                op_b = r_a[MUL_W-1:0];
            end
            MOP_ALO_AHI: begin
                op_a = r_a[MUL_W-1:0];
                op_b = r_a[PROD_W-1:MUL_W];
            end
            MOP_AHI_AHI: begin
                op_a = r_a[PROD_W-1:MUL_W];
                op_b = r_a[PROD_W-1:MUL_W];
            end
            MOP_T2LO_LLO: begin
                op_a = r_tol2[MUL_W-1:0];
                op_b = r_len[MUL_W-1:0];
            end
            MOP_T2LO_LHI: begin
                op_a = r_tol2[MUL_W-1:0];
                op_b = r_len[PROD_W-1:MUL_W];
            end
            MOP_T2HI_LLO: begin
                op_a = MUL_W'(r_tol2[TOL2_W-1:MUL_W]);
                op_b = r_len[MUL_W-1:0];
            end
            MOP_T2HI_LHI: begin
                op_a = MUL_W'(r_tol2[TOL2_W-1:MUL_W]);
                op_b = r_len[PROD_W-1:MUL_W];
            end
            MOP_EX_EX: begin
                op_a = MUL_W'(r_mex);
                op_b = MUL_W'(r_mex);
            end
            MOP_EY_EY: begin
                op_a = MUL_W'(r_mey);
                op_b = MUL_W'(r_mey);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_ext = ACC_W'(r_prod);

    // Multiply into r_prod, then land the product at the registered destination
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (i_cmd.a_calc) begin
            r_a <= a_val;
        end
        case (r_dst)
            DST_NONE: begin
            end
            DST_TOL2:        r_tol2 <= r_prod[TOL2_W-1:0];
            DST_P1:          r_p1   <= r_prod;
            DST_P2:          r_p2   <= r_prod;
            DST_LEN_SET:     r_len  <= r_prod;
            DST_LEN_ADD:     r_len  <= r_len + r_prod;
            DST_LHS_SET:     r_lhs  <= prod_ext;
            DST_LHS_ADD:     r_lhs  <= r_lhs + prod_ext;
            DST_LHS_ADD_X2:  r_lhs  <= r_lhs + (prod_ext << SH_CROSS);
            DST_LHS_ADD_HI:  r_lhs  <= r_lhs + (prod_ext << SH_FULL);
            DST_RHS_SET:     r_rhs  <= prod_ext;
            DST_RHS_ADD_MID: r_rhs  <= r_rhs + (prod_ext << SH_HALF);
            DST_RHS_ADD_HI:  r_rhs  <= r_rhs + (prod_ext << SH_FULL);
            default: begin
            end
        endcase
    end

    // Final compares: plain distance for a zero-length segment
    assign hit_zero = r_lhs < ACC_W'(r_tol2);
    assign hit_seg  = r_lhs < r_rhs;

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res.hit_found    <= i_cmd.res_hit & r_hit;
            r_res.vertex_count <= n_count;
            r_res.store_full   <= i_cmd.res_full;
        end
    end

    assign o_result = r_res;

    // Status to the controller
    always_comb begin
        o_sts          = '0;
        o_sts.cnt_lt2  = r_count < CNT_W'(2);
        o_sts.full     = r_count == CNT_W'(MAX_VERTICES);
        o_sts.first    = r_idx == CNT_W'(1);
        o_sts.last     = r_idx == r_count;
        o_sts.vtx_hit  = vtx_hit;
        o_sts.in_box   = in_box;
        o_sts.zero_len = zero_len;
        o_sts.hit_zero = hit_zero;
        o_sts.hit_seg  = hit_seg;
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_VERTICES),
        "vertex count above store depth")

    `ASSERT_IMPL(a_append_room, i_clk, i_rst_n, i_cmd.append,
        r_count < CNT_W'(MAX_VERTICES), "append issued to a full store")

    `ASSERT_IMPL(a_load_in_range, i_clk, i_rst_n, i_cmd.ld, r_idx < r_count,
        "scan read past the stored vertices")

endmodule
